@@ hdl/fct_pkg.sv @@
// shared types and constants for the frustum cull test unit
package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COORD_W     = 24;
    localparam int RADIUS_W    = 23;
    localparam int NORM_W      = 12;
    localparam int DIST_W      = 28;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    // wide enough for every dot product, extent sum and shifted distance
    localparam int ACC_W       = 42;

    // distance scaling: q19.8 distance against q1.10 * q15.8 products
    localparam int SPHERE_SHIFT = 10;
    localparam int BOX_SHIFT    = 11;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_NEAR   = 3'd0,
        REG_PLANE_FAR    = 3'd1,
        REG_PLANE_LEFT   = 3'd2,
        REG_PLANE_RIGHT  = 3'd3,
        REG_PLANE_TOP    = 3'd4,
        REG_PLANE_BOTTOM = 3'd5
    } reg_idx_t;

    // volume kinds carried on tuser
    localparam logic FUNC_SPHERE = 1'b0;
    localparam logic FUNC_BOX    = 1'b1;

    typedef logic signed [ACC_W-1:0] acc_t;

    // one plane register, lowest field last
    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } plane_t;

    // one volume as packed on s_tdata, first_x in the lowest bits
    typedef struct packed {
        logic        [RADIUS_W-1:0] radius;
        logic signed [COORD_W-1:0]  second_z;
        logic signed [COORD_W-1:0]  second_y;
        logic signed [COORD_W-1:0]  second_x;
        logic signed [COORD_W-1:0]  first_z;
        logic signed [COORD_W-1:0]  first_y;
        logic signed [COORD_W-1:0]  first_x;
    } vol_t;

    localparam int VOL_W     = $bits(vol_t);
    localparam int S_TDATA_W = ((VOL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

endpackage

@@ hdl/fct_plane_regs.sv @@
// six plane configuration registers with write decode
module fct_plane_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [fct_pkg::CFG_W-1:0]              cfg_wdata,
    output fct_pkg::plane_t [fct_pkg::PLANE_COUNT-1:0] planes_o
);

    fct_pkg::plane_t [fct_pkg::PLANE_COUNT-1:0] planes_reg;
    fct_pkg::plane_t [fct_pkg::PLANE_COUNT-1:0] planes_next;

    always_comb begin
        planes_next = planes_reg;
        if (cfg_we) begin
            unique case (fct_pkg::reg_idx_t'(cfg_index))
                fct_pkg::REG_PLANE_NEAR:   planes_next[0] = fct_pkg::plane_t'(cfg_wdata);
                fct_pkg::REG_PLANE_FAR:    planes_next[1] = fct_pkg::plane_t'(cfg_wdata);
                fct_pkg::REG_PLANE_LEFT:   planes_next[2] = fct_pkg::plane_t'(cfg_wdata);
                fct_pkg::REG_PLANE_RIGHT:  planes_next[3] = fct_pkg::plane_t'(cfg_wdata);
                fct_pkg::REG_PLANE_TOP:    planes_next[4] = fct_pkg::plane_t'(cfg_wdata);
                fct_pkg::REG_PLANE_BOTTOM: planes_next[5] = fct_pkg::plane_t'(cfg_wdata);
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planes_reg <= '0;
        end else begin
            planes_reg <= planes_next;
        end
    end

    assign planes_o = planes_reg;

endmodule

@@ hdl/fct_plane_test.sv @@
// one plane against one sphere or box, pure logic
module fct_plane_test (
    input  fct_pkg::plane_t plane_i,
    input  logic            is_box_i,
    input  fct_pkg::vol_t   vol_i,
    output logic            pass_o
);

    logic signed [fct_pkg::NORM_W-1:0]  n   [3];
    logic signed [fct_pkg::COORD_W-1:0] a   [3];
    logic signed [fct_pkg::COORD_W-1:0] b   [3];
    logic signed [fct_pkg::COORD_W:0]   p   [3];
    logic signed [fct_pkg::COORD_W:0]   e   [3];
    logic        [fct_pkg::NORM_W-1:0]  mag [3];
    logic signed [fct_pkg::COORD_W+fct_pkg::NORM_W:0]   dprod [3];
    logic signed [fct_pkg::COORD_W+fct_pkg::NORM_W+1:0] rprod [3];
    fct_pkg::acc_t dot;
    fct_pkg::acc_t r2;
    fct_pkg::acc_t dterm;
    fct_pkg::acc_t bound;
    fct_pkg::acc_t slack;

    assign n[0] = plane_i.nx;
    assign n[1] = plane_i.ny;
    assign n[2] = plane_i.nz;
    assign a[0] = vol_i.first_x;
    assign a[1] = vol_i.first_y;
    assign a[2] = vol_i.first_z;
    assign b[0] = vol_i.second_x;
    assign b[1] = vol_i.second_y;
    assign b[2] = vol_i.second_z;

    // per axis: box uses doubled center (min+max) and doubled extent (max-min)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p[i]     = is_box_i ? (25'(a[i]) + 25'(b[i])) : 25'(a[i]);
            e[i]     = 25'(b[i]) - 25'(a[i]);
            mag[i]   = n[i][fct_pkg::NORM_W-1] ? 12'(-n[i]) : 12'(n[i]);
            dprod[i] = p[i] * n[i];
            rprod[i] = e[i] * $signed({1'b0, mag[i]});
        end
    end

    always_comb begin
        dot = fct_pkg::acc_t'(dprod[0]) + fct_pkg::acc_t'(dprod[1])
            + fct_pkg::acc_t'(dprod[2]);
        r2  = fct_pkg::acc_t'(rprod[0]) + fct_pkg::acc_t'(rprod[1])
            + fct_pkg::acc_t'(rprod[2]);
        if (is_box_i) begin
            dterm = fct_pkg::acc_t'(plane_i.distance) <<< fct_pkg::BOX_SHIFT;
            bound = r2;
        end else begin
            dterm = fct_pkg::acc_t'(plane_i.distance) <<< fct_pkg::SPHERE_SHIFT;
            bound = fct_pkg::acc_t'({1'b0, vol_i.radius}) <<< fct_pkg::SPHERE_SHIFT;
        end
        slack = dot - dterm + bound;
        // box passes on touching, sphere needs strict clearance
        if (is_box_i) begin
            pass_o = !slack[fct_pkg::ACC_W-1];
        end else begin
            pass_o = !slack[fct_pkg::ACC_W-1] && (slack != '0);
        end
    end

endmodule

@@ hdl/frustum_cull_test_unit.sv @@
// top level of the frustum cull test unit
// Tests one sphere or axis-aligned box per request against six frustum planes
// and returns one visible flag per request, in order. Throughput is one request
// per clock unless s_tready drops. The input register feeds a single pass of
// per-plane arithmetic (six lanes, each three small dot-product multipliers
// and three extent multipliers), whose outcome the result register takes and
// drives onto m_tdata as the visible bit under m_tvalid. The result register
// parts the two sides, so a new request is taken while a finished result waits,
// and s_tready only drops when both registers hold requests and m_tready is low.
// Plane registers are written through cfg_we/cfg_index/cfg_wdata and must only
// change while no request is in flight; they reset to zero, which makes every
// box visible and a sphere visible only with a nonzero radius. Indexes above
// five are ignored.
module frustum_cull_test_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, radius, zero pad
    input  logic [fct_pkg::S_TDATA_W-1:0]    s_tdata,
    // func: 0 sphere, 1 box
    input  logic                             s_tuser,
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // visible, zero pad
    output logic [fct_pkg::M_TDATA_W-1:0]    m_tdata,
    // plane register writes
    input  logic                             cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fct_pkg::CFG_W-1:0]        cfg_wdata
);

    fct_pkg::plane_t [fct_pkg::PLANE_COUNT-1:0] planes;

    // input stage
    logic          in_valid_reg;
    logic          in_valid_next;
    fct_pkg::vol_t vol_reg;
    logic          is_box_reg;

    // result stage
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          visible_reg;

    logic [fct_pkg::PLANE_COUNT-1:0] pass;
    logic          s_fire;
    logic          out_adv;   // result stage can take the input stage's request

    fct_plane_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .planes_o  (planes)
    );

    // one lane per plane, all in parallel
    for (genvar g = 0; g < fct_pkg::PLANE_COUNT; g++) begin : g_plane
        fct_plane_test u_test (
            .plane_i  (planes[g]),
            .is_box_i (is_box_reg),
            .vol_i    (vol_reg),
            .pass_o   (pass[g])
        );
    end

    // handshake: stage moves when the result slot is empty or being drained
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !out_adv);
    assign out_valid_next = (in_valid_reg && out_adv) || (out_valid_reg && !m_tready);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, loaded only when its stage takes a request
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            vol_reg    <= fct_pkg::vol_t'(s_tdata[fct_pkg::VOL_W-1:0]);
            is_box_reg <= (s_tuser == fct_pkg::FUNC_BOX);
        end
        if (in_valid_reg && out_adv) begin
            visible_reg <= &pass;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fct_pkg::M_TDATA_W-1){1'b0}}, visible_reg};

endmodule

@@ hdl/fct_checker.sv @@
// port-level checks for the frustum cull test unit, bound to the top level
module fct_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fct_pkg::M_TDATA_W-1:0] m_tdata
);

    // requests accepted but not yet delivered
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_tvalid && s_tready && !(m_tvalid && m_tready)) begin
            pend_next = pend_reg + 2'd1;
        end else if (!(s_tvalid && s_tready) && m_tvalid && m_tready) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no result without a request behind it
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without pending request");

    // two storage slots only
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("more requests in flight than stages");

    // full and stalled means no new request taken
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 2'd2 && !m_tready |-> !s_tready)
        else $error("request taken while both stages full");

    // pad bits stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[fct_pkg::M_TDATA_W-1:1] == '0)
        else $error("result pad bits set");

endmodule

bind frustum_cull_test_unit fct_checker u_fct_checker (.*);

@@ dv/tb_top.sv @@
// self-checking testbench for the frustum cull test unit: scoreboard class and stimulus
module tb_top;
    import fct_pkg::*;

    // write indexes past the plane map, the block drops them
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    localparam logic [COORD_W-1:0]  COORD_MAX  = 24'h7FFFFF;
    localparam logic [COORD_W-1:0]  COORD_MIN  = 24'h800000;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = 23'h7FFFFF;
    localparam int NORM_MAX  = 2047;
    localparam int NORM_MIN  = -2048;
    localparam int DIST_MAX  = (1 << 27) - 1;
    localparam int DIST_MIN  = -(1 << 27);
    localparam int UNIT      = 1024;   // 1.0 as a q1.10 normal
    localparam int BOUND     = 25600;  // 100.0 in q15.8

    localparam int CHOKE_CYCLES  = 400;
    localparam int PHASE_ITEMS   = 117;
    localparam int RANDOM_PHASES = 8;

    // which axis each plane register faces: near/far z, left/right x, top/bottom y
    localparam int AXIS_OF [PLANE_COUNT] = '{2, 2, 0, 0, 1, 1};

    typedef logic [CFG_W-1:0] plane_set_t [PLANE_COUNT];
    typedef enum int {PLANES_AXIS, PLANES_SKEWED, PLANES_RAW} plane_mode_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the plane registers, queue of visible flags
    // ------------------------------------------------------------------
    class cull_scoreboard;
        logic [CFG_W-1:0] planes [PLANE_COUNT];
        bit               visible_q [$];
        int unsigned      mismatches;

        function new();
            foreach (planes[i]) planes[i] = '0;
            mismatches = 0;
        endfunction

        // writes past the plane map leave the planes alone
        function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx < PLANE_COUNT) planes[idx] = val;
        endfunction

        // signed distance test of one volume against all six planes,
        // full 64-bit arithmetic so nothing wraps
        function bit visible_for(logic func, vol_t v);
            longint lo [3];
            longint hi [3];
            longint nrm [3];
            longint offs, dot, reach, rad;
            bit     vis;
            lo[0] = $signed(v.first_x);
            lo[1] = $signed(v.first_y);
            lo[2] = $signed(v.first_z);
            hi[0] = $signed(v.second_x);
            hi[1] = $signed(v.second_y);
            hi[2] = $signed(v.second_z);
            rad   = longint'(v.radius);
            vis   = 1'b1;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                nrm[0] = $signed(planes[p][11:0]);
                nrm[1] = $signed(planes[p][23:12]);
                nrm[2] = $signed(planes[p][35:24]);
                offs   = $signed(planes[p][63:36]);
                dot    = 0;
                reach  = 0;
                if (func == FUNC_SPHERE) begin
                    // strict: a sphere just touching the plane is culled
                    for (int k = 0; k < 3; k++) dot += nrm[k] * lo[k];
                    if (!((dot - (offs <<< SPHERE_SHIFT)) > -(rad <<< SPHERE_SHIFT)))
                        vis = 1'b0;
                end else begin
                    // doubled center and extent; min above max stays unordered
                    for (int k = 0; k < 3; k++) begin
                        dot   += nrm[k] * (lo[k] + hi[k]);
                        reach += (hi[k] - lo[k]) * ((nrm[k] < 0) ? -nrm[k] : nrm[k]);
                    end
                    if (!((dot - (offs <<< BOX_SHIFT)) >= -reach))
                        vis = 1'b0;
                end
            end
            return vis;
        endfunction

        function void note_request(logic func, vol_t v);
            visible_q.push_back(visible_for(func, v));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            bit want;
            if (visible_q.size() == 0) begin
                $error("visible: expected none, got %0d", data[0]);
                mismatches++;
                return;
            end
            want = visible_q.pop_front();
            if (data[0] !== want) begin
                $error("visible: expected %0d, got %0d", want, data[0]);
                mismatches++;
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    cull_scoreboard sb = new();

    // idling controls shared by the sender and the receiver
    bit tx_gaps    = 1'b1;
    bit rx_eager   = 1'b0;
    int choke_req  = 0;   // bumped by the stimulus to ask for a long hold-off
    int choke_seen = 0;
    int rx_hold    = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    frustum_cull_test_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // idle length: mostly from the shortest range, sometimes from a middle one, rarely long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 93) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CFG_W-1:0] make_plane(int nx, int ny, int nz, int d);
        return {28'(d), 12'(nz), 12'(ny), 12'(nx)};
    endfunction

    // coordinate within +/- span, with a few full-range and extreme values
    function automatic logic [COORD_W-1:0] rand_coord(int span);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return COORD_W'($urandom);
        if (pick == 1) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // box size along one axis, now and then negative (min above max)
    function automatic logic [COORD_W-1:0] rand_extent(int span);
        if ($urandom_range(0, 7) == 0)
            return COORD_W'(-int'($urandom_range(0, span / 4)));
        return COORD_W'($urandom_range(0, span / 2));
    endfunction

    // plane set for one random phase; span says how far the volumes should reach
    function automatic plane_set_t build_planes(plane_mode_t mode, output int span);
        plane_set_t ps;
        int         nrm [3];
        int         lim;
        case (mode)
            PLANES_AXIS: begin
                // a rough box around the origin, normals facing inward, a little tilt
                lim  = $urandom_range(256, 1 << 18);
                span = lim + lim / 2;
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    for (int k = 0; k < 3; k++) nrm[k] = int'($urandom_range(0, 400)) - 200;
                    nrm[AXIS_OF[p]] = int'($urandom_range(700, NORM_MAX));
                    if (p % 2) nrm[AXIS_OF[p]] = -nrm[AXIS_OF[p]];
                    ps[p] = make_plane(nrm[0], nrm[1], nrm[2],
                                       int'($urandom_range(0, 512)) - 256 - lim);
                end
            end
            PLANES_SKEWED: begin
                span = 1 << 16;
                for (int p = 0; p < PLANE_COUNT; p++)
                    ps[p] = make_plane($urandom, $urandom, $urandom,
                                       int'($urandom_range(0, 1 << 17)) - (1 << 16));
            end
            default: begin
                span = (1 << 23) - 1;
                for (int p = 0; p < PLANE_COUNT; p++) ps[p] = {$urandom, $urandom};
            end
        endcase
        return ps;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one register write per clock; the caller lowers cfg_we after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_plane(idx, val);
    endtask

    task automatic load_planes(input plane_set_t ps);
        for (int p = 0; p < PLANE_COUNT; p++) write_reg(reg_idx_t'(p), ps[p]);
        cfg_we <= 1'b0;
    endtask

    // offer one request, with an optional gap first, and hold it until taken
    task automatic send_volume(input logic func, input vol_t v);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(S_TDATA_W - VOL_W){1'b0}}, v};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, v);
    endtask

    // second corner carries random bits, the block must ignore it
    task automatic send_sphere(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z, input logic [RADIUS_W-1:0] r);
        vol_t v;
        v.first_x  = x;
        v.first_y  = y;
        v.first_z  = z;
        v.second_x = COORD_W'($urandom);
        v.second_y = COORD_W'($urandom);
        v.second_z = COORD_W'($urandom);
        v.radius   = r;
        send_volume(FUNC_SPHERE, v);
    endtask

    // radius carries random bits, the block must ignore it
    task automatic send_box(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                            input logic [COORD_W-1:0] z0, input logic [COORD_W-1:0] x1,
                            input logic [COORD_W-1:0] y1, input logic [COORD_W-1:0] z1);
        vol_t v;
        v.first_x  = x0;
        v.first_y  = y0;
        v.first_z  = z0;
        v.second_x = x1;
        v.second_y = y1;
        v.second_z = z1;
        v.radius   = RADIUS_W'($urandom);
        send_volume(FUNC_BOX, v);
    endtask

    task automatic send_random(input int span);
        vol_t v;
        logic func;
        int   pick;
        func       = $urandom_range(0, 1) ? FUNC_BOX : FUNC_SPHERE;
        v.first_x  = rand_coord(span);
        v.first_y  = rand_coord(span);
        v.first_z  = rand_coord(span);
        if (func == FUNC_BOX) begin
            v.second_x = v.first_x + rand_extent(span);
            v.second_y = v.first_y + rand_extent(span);
            v.second_z = v.first_z + rand_extent(span);
        end else begin
            v.second_x = rand_coord(span);
            v.second_y = rand_coord(span);
            v.second_z = rand_coord(span);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)      v.radius = '0;
        else if (pick == 1) v.radius = RADIUS_W'($urandom);
        else                v.radius = RADIUS_W'($urandom_range(0, span / 2));
        send_volume(func, v);
    endtask

    // planes may only change with nothing in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, eager stretches, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (choke_req != choke_seen) begin
                choke_seen = choke_req;
                rx_hold    = CHOKE_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_eager || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
            end else begin
                rx_hold = idle_len();
                m_tready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        plane_set_t  ps;
        int          span;
        plane_mode_t mode;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // planes at reset: zero-radius sphere culled, any other sphere and every box pass
        send_sphere('0, '0, '0, '0);
        send_sphere('0, '0, '0, 23'd1);
        send_sphere(COORD_MIN, COORD_MAX, COORD_MIN, RADIUS_MAX);
        send_box(-24'sd100, -24'sd100, -24'sd100, 24'sd100, 24'sd100, 24'sd100);
        send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        settle();

        // writes past the plane map must not land anywhere
        write_reg(IDX_UNMAPPED_LO, {$urandom, $urandom});
        write_reg(IDX_UNMAPPED_HI, '1);
        cfg_we <= 1'b0;
        send_sphere('0, '0, '0, '0);
        settle();

        // axis-aligned cube of half-size 100.0 around the origin
        ps[REG_PLANE_NEAR]   = make_plane(0, 0, UNIT, -BOUND);
        ps[REG_PLANE_FAR]    = make_plane(0, 0, -UNIT, -BOUND);
        ps[REG_PLANE_LEFT]   = make_plane(UNIT, 0, 0, -BOUND);
        ps[REG_PLANE_RIGHT]  = make_plane(-UNIT, 0, 0, -BOUND);
        ps[REG_PLANE_TOP]    = make_plane(0, -UNIT, 0, -BOUND);
        ps[REG_PLANE_BOTTOM] = make_plane(0, UNIT, 0, -BOUND);
        load_planes(ps);
        send_sphere('0, '0, '0, '0);
        // sphere touching the left plane: culled at zero radius, kept at radius one
        send_sphere(COORD_W'(-BOUND), '0, '0, '0);
        send_sphere(COORD_W'(-BOUND), '0, '0, 23'd1);
        // box touching the left plane from outside passes, one step further fails
        send_box(COORD_W'(-BOUND - 10), '0, '0, COORD_W'(-BOUND), '0, '0);
        send_box(COORD_W'(-BOUND - 11), '0, '0, COORD_W'(-BOUND - 1), '0, '0);
        // min above max: extent goes negative and shrinks the box
        send_box(24'sd10, 24'sd10, 24'sd10, -24'sd10, -24'sd10, -24'sd10);
        send_box(COORD_W'(-BOUND + 5), '0, '0, COORD_W'(-BOUND - 5), '0, '0);
        send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        settle();

        // extreme plane fields, mostly culling
        ps[REG_PLANE_NEAR]   = make_plane(NORM_MIN, NORM_MIN, NORM_MIN, DIST_MAX);
        ps[REG_PLANE_FAR]    = make_plane(NORM_MAX, NORM_MAX, NORM_MAX, DIST_MIN);
        ps[REG_PLANE_LEFT]   = '1;
        ps[REG_PLANE_RIGHT]  = make_plane(NORM_MAX, NORM_MIN, 0, 0);
        ps[REG_PLANE_TOP]    = make_plane(0, NORM_MAX, NORM_MIN, DIST_MIN);
        ps[REG_PLANE_BOTTOM] = '0;
        load_planes(ps);
        send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
        send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, '0);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        settle();

        // extreme fields with distances far behind every volume: everything passes
        foreach (ps[p])
            ps[p] = (p % 2) ? make_plane(NORM_MIN, NORM_MIN, NORM_MIN, DIST_MIN)
                            : make_plane(NORM_MAX, NORM_MAX, NORM_MAX, DIST_MIN);
        load_planes(ps);
        send_sphere(COORD_MIN, COORD_MIN, COORD_MIN, '0);
        send_sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
        send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        settle();

        // random phases: a new plane set each, mostly boxes around the origin
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                1:       mode = PLANES_SKEWED;
                3:       mode = (ph == 3) ? PLANES_AXIS : PLANES_RAW;
                default: mode = PLANES_AXIS;
            endcase
            ps = build_planes(mode, span);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? IDX_UNMAPPED_LO : IDX_UNMAPPED_HI,
                          {$urandom, $urandom});
            load_planes(ps);
            // one phase with no gaps on either side, one with the receiver choked
            tx_gaps  = (ph != 1) && (ph != 3);
            rx_eager = (ph == 1);
            if (ph == 3) choke_req++;
            repeat (PHASE_ITEMS) send_random(span);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("frustum_cull_test_unit: match");
        else
            $display("frustum_cull_test_unit: mismatch");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #2000000;
        $display("frustum_cull_test_unit: mismatch");
        $finish;
    end

endmodule
